// File: design/zou_he_boundary_d2q9_macros.svh
// Assertion macros shared by the checker of the boundary rebuild block.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef ZOU_HE_BOUNDARY_D2Q9_MACROS_SVH
`define ZOU_HE_BOUNDARY_D2Q9_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ZHB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zhb checker: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ZHB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zhb checker: assertion failed");

`endif

// File: design/zhb_pkg.sv
// Shared types, constants and helper functions of the Zou-He boundary block.
// Used by every design module of the block but the checker; depends on nothing.
package zhb_pkg;

  localparam int QW   = 18;
  localparam int FRAC = 16;

  localparam int NUM1_W = 22;
  localparam int DEN1_W = 19;
  localparam int MOM_W  = 21;
  localparam int PD_W   = 17;

  localparam int FIFO_DEPTH_DEF = 2;

  localparam logic [PD_W-1:0] PD_RESET = 17'd65536;
  localparam logic signed [23:0] ONE_Q16 = 24'sd65536;

  localparam logic signed [QW-1:0] SAT_MAX = 18'sh1FFFF;
  localparam logic signed [QW-1:0] SAT_MIN = 18'sh20000;
  localparam logic [QW:0] MAG_MAX_POS = 19'd131071;
  localparam logic [QW:0] MAG_MAX_NEG = 19'd131072;

  // floor(x / 3) as (x * K) >> S, exact for x below 2^21.
  localparam logic [20:0] DIV3_K  = 21'd1398102;
  localparam int          DIV3_SH = 22;

  localparam logic ACT_INLET  = 1'b0;
  localparam logic ACT_OUTLET = 1'b1;

  typedef struct packed {
    logic                     outlet;
    logic [8:0][QW-1:0]       f;
    logic signed [NUM1_W-1:0] num1;
    logic signed [DEN1_W-1:0] den1;
    logic signed [QW-1:0]     mb;
    logic signed [QW-1:0]     half;
  } item_t;

  typedef struct packed {
    logic               err;
    logic [2:0][QW-1:0] nv;
    logic [QW-1:0]      dens;
  } rebuilt_t;

  function automatic logic signed [QW-1:0] sat18(input logic signed [23:0] v);
    logic signed [QW-1:0] r;
    if (v > 24'sd131071) begin
      r = SAT_MAX;
    end else if (v < -24'sd131072) begin
      r = SAT_MIN;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic [18:0] div3(input logic [20:0] x);
    logic [41:0] p;
    p = 42'(x) * 42'(DIV3_K);
    return p[DIV3_SH +: 19];
  endfunction

endpackage

// File: design/zhb_front.sv
// Front end: accepts a cell, forms the divider operands and the half term.
// Depends on zhb_pkg.
module zhb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [183:0]                  in_tdata,
  input  logic [0:0]                    in_tuser,
  input  logic [zhb_pkg::PD_W-1:0]      pd,
  input  logic                          push_ok,
  output logic                          push,
  output zhb_pkg::item_t                push_item
);

  logic                           fv_r, fv_nxt;
  zhb_pkg::item_t                 item_r, item_nxt;
  logic signed [zhb_pkg::QW-1:0]  f_w [9];
  logic signed [zhb_pkg::QW-1:0]  u_w;
  logic signed [21:0]             base_w, side_in_w, side_out_w;
  logic signed [18:0]             diff_w, half_w;
  logic                           outlet_w;
  logic                           accept_w;

  assign push      = fv_r && push_ok;
  assign in_tready = !fv_r || push_ok;
  assign accept_w  = in_tvalid && in_tready;
  assign push_item = item_r;

  always_comb begin
    u_w = $signed(in_tdata[zhb_pkg::QW-1:0]);
    for (int k = 0; k < 9; k++) begin
      f_w[k] = $signed(in_tdata[zhb_pkg::QW*(k+1) +: zhb_pkg::QW]);
    end
    outlet_w   = (in_tuser[0] == zhb_pkg::ACT_OUTLET);
    base_w     = 22'(f_w[0]) + 22'(f_w[2]) + 22'(f_w[4]);
    side_in_w  = 22'(f_w[3]) + 22'(f_w[6]) + 22'(f_w[7]);
    side_out_w = 22'(f_w[1]) + 22'(f_w[5]) + 22'(f_w[8]);
    // Halving truncates toward zero, so negative differences are bumped first.
    diff_w     = 19'(f_w[2]) - 19'(f_w[4]);
    half_w     = (diff_w + $signed({18'd0, diff_w[18]})) >>> 1;

    item_nxt.outlet = outlet_w;
    for (int k = 0; k < 9; k++) begin
      item_nxt.f[k] = f_w[k];
    end
    item_nxt.half = half_w[zhb_pkg::QW-1:0];
    if (outlet_w) begin
      item_nxt.num1 = base_w + (side_out_w <<< 1);
      item_nxt.den1 = $signed({2'b00, pd});
      item_nxt.mb   = $signed({1'b0, pd});
    end else begin
      item_nxt.num1 = base_w + (side_in_w <<< 1);
      item_nxt.den1 = 19'sd65536 - 19'(u_w);
      item_nxt.mb   = u_w;
    end
  end

  always_comb begin
    fv_nxt = fv_r;
    if (accept_w) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_w) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: design/zhb_fifo.sv
// Short queue between the front end and the arithmetic back end.
// Depends on zhb_pkg.
module zhb_fifo #(
  parameter int DEPTH = zhb_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  zhb_pkg::item_t push_item,
  output logic           push_ok,
  input  logic           pop,
  output logic           head_vld,
  output zhb_pkg::item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  zhb_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign push_ok   = (cnt_r != CNT_W'(DEPTH));
  assign head_vld  = (cnt_r != '0);
  assign head_item = mem_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

// File: design/zhb_div.sv
// Pipelined restoring divider for saturated signed Q.16 quotients, one bit a stage.
// Depends on zhb_pkg. The pipeline advances only while en is high.
module zhb_div #(
  parameter int NW = zhb_pkg::NUM1_W,
  parameter int DW = zhb_pkg::DEN1_W,
  parameter int PW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [NW-1:0]          num_i,
  input  logic signed [DW-1:0]          den_i,
  input  logic [PW-1:0]                 pl_i,
  output logic                          vld_o,
  output logic signed [zhb_pkg::QW-1:0] q_o,
  output logic                          err_o,
  output logic [PW-1:0]                 pl_o
);

  localparam int QW  = zhb_pkg::QW;
  localparam int NST = QW + 1;
  localparam int AW  = NW + zhb_pkg::FRAC;
  localparam int CW  = (AW > DW + QW) ? AW : DW + QW;

  typedef struct packed {
    logic neg;
    logic err;
    logic ovf;
  } dflag_t;

  logic [CW-1:0]   rem_r [NST];
  logic [QW-1:0]   q_r   [NST];
  logic [DW-2:0]   dm_r  [NST];
  dflag_t          flg_r [NST];
  logic [PW-1:0]   pl_r  [NST];
  logic            vld_r [NST];

  logic [NW-1:0]   nmag_w;
  logic [CW-1:0]   r0_w, d0_w;
  logic [CW-1:0]   dsh_w [NST];
  logic            ge_w  [NST];
  logic [QW:0]     mag_w;
  dflag_t          fl_w;

  always_comb begin
    nmag_w = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    r0_w   = CW'({nmag_w, {zhb_pkg::FRAC{1'b0}}});
    d0_w   = CW'(den_i[DW-2:0]);
    dsh_w[0] = '0;
    ge_w[0]  = 1'b0;
    for (int k = 1; k < NST; k++) begin
      dsh_w[k] = CW'(dm_r[k-1]) << (QW - k);
      ge_w[k]  = (rem_r[k-1] >= dsh_w[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int k = 1; k < NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]     <= r0_w;
      q_r[0]       <= '0;
      dm_r[0]      <= den_i[DW-2:0];
      flg_r[0].neg <= num_i[NW-1];
      flg_r[0].err <= den_i[DW-1] || (den_i == '0);
      // A quotient of 2^18 or more can only saturate.
      flg_r[0].ovf <= (r0_w >= (d0_w << QW));
      pl_r[0]      <= pl_i;
      for (int k = 1; k < NST; k++) begin
        rem_r[k] <= ge_w[k] ? rem_r[k-1] - dsh_w[k] : rem_r[k-1];
        q_r[k]   <= ge_w[k] ? (q_r[k-1] | (QW'(1) << (QW - k))) : q_r[k-1];
        dm_r[k]  <= dm_r[k-1];
        flg_r[k] <= flg_r[k-1];
        pl_r[k]  <= pl_r[k-1];
      end
    end
  end

  always_comb begin
    fl_w  = flg_r[NST-1];
    mag_w = fl_w.ovf ? {1'b1, {QW{1'b0}}} : {1'b0, q_r[NST-1]};
    if (fl_w.err) begin
      q_o = fl_w.neg ? zhb_pkg::SAT_MIN : zhb_pkg::SAT_MAX;
    end else if (!fl_w.neg) begin
      q_o = (mag_w > zhb_pkg::MAG_MAX_POS) ? zhb_pkg::SAT_MAX : $signed(mag_w[QW-1:0]);
    end else begin
      q_o = (mag_w > zhb_pkg::MAG_MAX_NEG) ? zhb_pkg::SAT_MIN : $signed(-mag_w[QW-1:0]);
    end
  end

  assign err_o = fl_w.err;
  assign vld_o = vld_r[NST-1];
  assign pl_o  = pl_r[NST-1];

endmodule

// File: design/zhb_back.sv
// Back end: boundary density or velocity, rebuild of the unknowns, moments and output.
// Depends on zhb_pkg and zhb_div.
module zhb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_vld,
  input  zhb_pkg::item_t head_item,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [111:0]   out_tdata,
  output logic [0:0]     out_tuser
);

  localparam int QW = zhb_pkg::QW;

  logic adv_w;

  // First divider: inlet density, or the outlet ratio that gives the velocity.
  logic                  d1_vld_w, d1_err_w;
  logic signed [QW-1:0]  d1_q_w;
  logic [$bits(zhb_pkg::item_t)-1:0] d1_pl_w;
  zhb_pkg::item_t        d1_item_w;

  logic signed [QW-1:0]  a_w;
  logic signed [35:0]    t_w;

  logic                  m_vld_r, m_err_r;
  logic signed [35:0]    m_t_r;
  zhb_pkg::item_t        m_item_r;

  logic [35:0]           at_w;
  logic [18:0]           two3m_w, sixm_w;

  logic                  r_vld_r, r_err_r;
  logic signed [19:0]    r_two3_r, r_six_r;
  zhb_pkg::item_t        r_item_r;

  logic signed [21:0]    e_w [3];
  logic [8:0][QW-1:0]    fn_w;
  logic [2:0][QW-1:0]    nv_w;
  logic signed [21:0]    f3_w, f7_w, f6_w, f1_w, f5_w, f8_w, half_w;

  logic                  e_vld_r, e_err_r;
  logic [8:0][QW-1:0]    e_f_r;
  logic [2:0][QW-1:0]    e_nv_r;

  logic signed [23:0]    sum_w;
  logic signed [zhb_pkg::MOM_W-1:0] mx_w, my_w;

  logic                  s_vld_r, s_err_r;
  logic signed [QW-1:0]  s_dens_r;
  logic signed [zhb_pkg::MOM_W-1:0] s_mx_r, s_my_r;
  logic [2:0][QW-1:0]    s_nv_r;

  zhb_pkg::rebuilt_t     s_pl_w;
  logic [$bits(zhb_pkg::rebuilt_t)-1:0] dx_pl_w;
  zhb_pkg::rebuilt_t     dx_rb_w;
  logic                  dx_vld_w, dx_err_w, dy_err_w;
  logic signed [QW-1:0]  dx_q_w, dy_q_w;

  logic                  out_vld_r;
  logic [107:0]          out_data_r;
  logic                  out_err_r;

  assign adv_w = !out_vld_r || out_tready;
  assign pop   = adv_w && head_vld;

  zhb_div #(
    .NW (zhb_pkg::NUM1_W),
    .DW (zhb_pkg::DEN1_W),
    .PW ($bits(zhb_pkg::item_t))
  ) u_div_bnd (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv_w),
    .vld_i (head_vld),
    .num_i (head_item.num1),
    .den_i (head_item.den1),
    .pl_i  (head_item),
    .vld_o (d1_vld_w),
    .q_o   (d1_q_w),
    .err_o (d1_err_w),
    .pl_o  (d1_pl_w)
  );

  assign d1_item_w = zhb_pkg::item_t'(d1_pl_w);

  always_comb begin
    // The outlet velocity is the density ratio less one.
    a_w = d1_item_w.outlet ? zhb_pkg::sat18(24'(d1_q_w) - zhb_pkg::ONE_Q16) : d1_q_w;
    t_w = a_w * d1_item_w.mb;
  end

  always_comb begin
    at_w    = m_t_r[35] ? 36'(-m_t_r) : 36'(m_t_r);
    two3m_w = zhb_pkg::div3(at_w[35:15]);
    sixm_w  = zhb_pkg::div3(21'(at_w[35:17]));
  end

  always_comb begin
    f1_w   = 22'($signed(r_item_r.f[1]));
    f3_w   = 22'($signed(r_item_r.f[3]));
    f5_w   = 22'($signed(r_item_r.f[5]));
    f6_w   = 22'($signed(r_item_r.f[6]));
    f7_w   = 22'($signed(r_item_r.f[7]));
    f8_w   = 22'($signed(r_item_r.f[8]));
    half_w = 22'(r_item_r.half);
    if (r_item_r.outlet) begin
      e_w[0] = f1_w - 22'(r_two3_r);
      e_w[1] = f5_w - 22'(r_six_r) + half_w;
      e_w[2] = f8_w - 22'(r_six_r) - half_w;
    end else begin
      e_w[0] = f3_w + 22'(r_two3_r);
      e_w[1] = f7_w + 22'(r_six_r) - half_w;
      e_w[2] = f6_w + 22'(r_six_r) + half_w;
    end
    for (int k = 0; k < 3; k++) begin
      nv_w[k] = zhb_pkg::sat18(24'(e_w[k]));
    end
    fn_w = r_item_r.f;
    if (r_item_r.outlet) begin
      fn_w[3] = nv_w[0];
      fn_w[7] = nv_w[1];
      fn_w[6] = nv_w[2];
    end else begin
      fn_w[1] = nv_w[0];
      fn_w[5] = nv_w[1];
      fn_w[8] = nv_w[2];
    end
  end

  always_comb begin
    sum_w = '0;
    for (int k = 0; k < 9; k++) begin
      sum_w = sum_w + 24'($signed(e_f_r[k]));
    end
    mx_w = 21'($signed(e_f_r[1])) + 21'($signed(e_f_r[5])) + 21'($signed(e_f_r[8]))
         - 21'($signed(e_f_r[3])) - 21'($signed(e_f_r[6])) - 21'($signed(e_f_r[7]));
    my_w = 21'($signed(e_f_r[2])) + 21'($signed(e_f_r[5])) + 21'($signed(e_f_r[6]))
         - 21'($signed(e_f_r[4])) - 21'($signed(e_f_r[7])) - 21'($signed(e_f_r[8]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else if (adv_w) begin
      m_vld_r <= d1_vld_w;
      r_vld_r <= m_vld_r;
      e_vld_r <= r_vld_r;
      s_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_w) begin
      m_t_r    <= t_w;
      m_item_r <= d1_item_w;
      m_err_r  <= d1_err_w;

      r_two3_r <= m_t_r[35] ? -20'(two3m_w) : 20'(two3m_w);
      r_six_r  <= m_t_r[35] ? -20'(sixm_w) : 20'(sixm_w);
      r_item_r <= m_item_r;
      r_err_r  <= m_err_r;

      e_f_r    <= fn_w;
      e_nv_r   <= nv_w;
      e_err_r  <= r_err_r;

      s_dens_r <= zhb_pkg::sat18(sum_w);
      s_mx_r   <= mx_w;
      s_my_r   <= my_w;
      s_nv_r   <= e_nv_r;
      s_err_r  <= e_err_r;
    end
  end

  always_comb begin
    s_pl_w.err  = s_err_r;
    s_pl_w.nv   = s_nv_r;
    s_pl_w.dens = s_dens_r;
  end

  zhb_div #(
    .NW (zhb_pkg::MOM_W),
    .DW (QW),
    .PW ($bits(zhb_pkg::rebuilt_t))
  ) u_div_vx (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv_w),
    .vld_i (s_vld_r),
    .num_i (s_mx_r),
    .den_i (s_dens_r),
    .pl_i  (s_pl_w),
    .vld_o (dx_vld_w),
    .q_o   (dx_q_w),
    .err_o (dx_err_w),
    .pl_o  (dx_pl_w)
  );

  zhb_div #(
    .NW (zhb_pkg::MOM_W),
    .DW (QW),
    .PW (1)
  ) u_div_vy (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv_w),
    .vld_i (s_vld_r),
    .num_i (s_my_r),
    .den_i (s_dens_r),
    .pl_i  (1'b0),
    .vld_o (),
    .q_o   (dy_q_w),
    .err_o (dy_err_w),
    .pl_o  ()
  );

  assign dx_rb_w = zhb_pkg::rebuilt_t'(dx_pl_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv_w) begin
      out_vld_r <= dx_vld_w;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_w) begin
      out_data_r <= {dy_q_w, dx_q_w, dx_rb_w.dens, dx_rb_w.nv[2], dx_rb_w.nv[1], dx_rb_w.nv[0]};
      out_err_r  <= dx_rb_w.err | dx_err_w | dy_err_w;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_data_r};
  assign out_tuser  = out_err_r;

endmodule

// File: design/zou_he_boundary_d2q9.sv
// Top level of the Zou-He D2Q9 boundary rebuild block.
// Depends on zhb_pkg, zhb_front, zhb_fifo and zhb_back.
//
// Usage:
//   The input channel takes one boundary cell per beat: in_tuser selects a
//   velocity inlet on the west edge (0) or a density outlet on the east
//   edge (1), and in_tdata carries the prescribed x velocity and the nine
//   distributions. The output channel returns one beat per cell with the
//   three rebuilt distributions, the density and both velocity moments in
//   out_tdata, and a divide error flag in out_tuser.
//   The outlet density is written through cfg_we/cfg_wdata; the user must
//   write it only while no cell is in flight, which the block does not
//   enforce. Reset loads unit density. Two 19-stage pipelined dividers lie
//   in series on the path. Throughput is one cell per clock until the
//   receiver stalls; then the result waits in the output register and the
//   whole back end holds, while the front end and its two-entry queue keep
//   accepting until they fill. Reset empties every stage; no beat survives.
module zou_he_boundary_d2q9 #(
  parameter int FIFO_DEPTH = zhb_pkg::FIFO_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [zhb_pkg::PD_W-1:0] cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // inlet_velocity, dist_rest, dist_east, dist_north, dist_west, dist_south,
  // dist_northeast, dist_northwest, dist_southwest, dist_southeast, zero pad
  input  logic [183:0]             in_tdata,
  // action
  input  logic [0:0]               in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // new_axial, new_diag_a, new_diag_b, cell_density, cell_velocity_x,
  // cell_velocity_y, zero pad
  output logic [111:0]             out_tdata,
  // divide_error
  output logic [0:0]               out_tuser
);

  logic [zhb_pkg::PD_W-1:0] pd_r;
  logic                     push_w, push_ok_w, pop_w, head_vld_w;
  zhb_pkg::item_t           push_item_w, head_item_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r <= zhb_pkg::PD_RESET;
    end else if (cfg_we) begin
      pd_r <= cfg_wdata;
    end
  end

  zhb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pd        (pd_r),
    .push_ok   (push_ok_w),
    .push      (push_w),
    .push_item (push_item_w)
  );

  zhb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_w),
    .push_item (push_item_w),
    .push_ok   (push_ok_w),
    .pop       (pop_w),
    .head_vld  (head_vld_w),
    .head_item (head_item_w)
  );

  zhb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (head_vld_w),
    .head_item  (head_item_w),
    .pop        (pop_w),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: design/zhb_checker.sv
// Port-level checker for the boundary rebuild block, bound to the top level.
// Depends on zou_he_boundary_d2q9_macros.svh.
`include "zou_he_boundary_d2q9_macros.svh"

module zhb_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [0:0]   out_tuser
);

  logic out_hold_w;
  logic dens_bad_w;
  logic vx_sat_w;

  assign out_hold_w = out_tvalid && !out_tready;
  assign dens_bad_w = out_tvalid && (out_tdata[71] || out_tdata[71:54] == 18'd0);
  assign vx_sat_w   = (out_tdata[89:72] == 18'h1FFFF) || (out_tdata[89:72] == 18'h20000);

  `ZHB_ASSERT_NEXT(a_out_hold, out_hold_w, out_tvalid)
  `ZHB_ASSERT_NEXT(a_out_stable, out_hold_w, $stable(out_tdata) && $stable(out_tuser))
  // A density of zero or below cannot divide the moments.
  `ZHB_ASSERT_SAME(a_dens_err, dens_bad_w, out_tuser[0])
  `ZHB_ASSERT_SAME(a_dens_sat, dens_bad_w, vx_sat_w)

endmodule

bind zou_he_boundary_d2q9 zhb_checker u_zhb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
